>>> rtl/pcibar_pkg.sv
// Package for the PCI BAR sizing and address assignment block.
// Holds status and window codes and the structs passed between stages.
// No dependencies.
`default_nettype none

package pcibar_pkg;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_IO_FULL    = 3'd1;
  localparam logic [2:0] ST_MEM32_FULL = 3'd2;
  localparam logic [2:0] ST_LAST_SLOT  = 3'd3;
  localparam logic [2:0] ST_ZERO       = 3'd4;

  localparam logic [1:0] WIN_IO    = 2'd0;
  localparam logic [1:0] WIN_MEM32 = 2'd1;
  localparam logic [1:0] WIN_MEM64 = 2'd2;

  localparam logic [1:0] REG_IO_BASE    = 2'd0;
  localparam logic [1:0] REG_MEM32_BASE = 2'd1;
  localparam logic [1:0] REG_MEM64_BASE = 2'd2;

  // End of the 32-bit windows
  localparam logic [63:0] LIMIT32 = 64'h0000_0001_0000_0000;

  // Decoded BAR, held in the input register
  typedef struct packed {
    logic        implemented;
    logic        is_io;
    logic        is_wide;
    logic        prefetchable;
    logic [1:0]  win;
    logic [2:0]  status;     // tentative: ok, last slot or zero size
    logic [63:0] bar_size;
    logic [63:0] span;       // ones through the size bit: 2*size-1
  } decoded_t;

  typedef struct packed {
    logic        implemented;
    logic        is_io;
    logic        is_wide;
    logic        prefetchable;
    logic [63:0] bar_size;
    logic [63:0] assigned_addr;
    logic [2:0]  status;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/pcibar_decode.sv
// BAR type and size decode from the all-ones probe readback.
// Purely combinational; uses pcibar_pkg.
`default_nettype none

module pcibar_decode
  import pcibar_pkg::*;
#(
  parameter int NUM_BARS = 6
) (
  input  wire logic [2:0]  bar_index,
  input  wire logic [31:0] probe_low,
  input  wire logic [31:0] probe_high,
  output decoded_t         dec
);

  logic        impl;
  logic        io;
  logic        wide;
  logic        last_slot;
  logic [63:0] addr_mask;
  logic [63:0] mask_dec;

  always_comb begin
    impl = (probe_low != 32'd0);
    io   = probe_low[0];
    wide = !probe_low[0] && (probe_low[2:1] == 2'b10);
    last_slot = wide && (({1'b0, bar_index} + 4'd1) >= 4'(NUM_BARS));

    if (io) begin
      addr_mask = {32'd0, probe_low[31:2], 2'b00};
    end else if (wide) begin
      addr_mask = {probe_high, probe_low[31:4], 4'b0000};
    end else begin
      addr_mask = {32'd0, probe_low[31:4], 4'b0000};
    end

    // Isolate the lowest set bit and the mask up to it
    mask_dec = addr_mask - 64'd1;

    dec.implemented  = impl;
    dec.is_io        = io;
    dec.is_wide      = wide;
    dec.prefetchable = !io && probe_low[3];
    dec.span         = addr_mask ^ mask_dec;
    dec.bar_size     = addr_mask & ~mask_dec;

    if (io) begin
      dec.win = WIN_IO;
    end else if (wide) begin
      dec.win = WIN_MEM64;
    end else begin
      dec.win = WIN_MEM32;
    end

    dec.status = ST_OK;
    if (impl) begin
      if (last_slot) begin
        dec.status = ST_LAST_SLOT;
      end else if (addr_mask == 64'd0) begin
        dec.status = ST_ZERO;
      end
    end
    if (last_slot) begin
      dec.bar_size = 64'd0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pcibar_alloc.sv
// Window base registers, next-free pointers and align-up allocation.
// Uses pcibar_pkg; fed by the decoded BAR from the input register.
`default_nettype none

module pcibar_alloc
  import pcibar_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        step,
  input  wire logic        restart,
  input  wire decoded_t    dec,
  output result_t          res
);

  logic [31:0] io_base;
  logic [31:0] mem32_base;
  logic [63:0] mem64_base;
  logic [32:0] io_free;
  logic [32:0] mem32_free;
  logic [63:0] mem64_free;
  logic [32:0] io_free_next;
  logic [32:0] mem32_free_next;
  logic [63:0] mem64_free_next;

  logic [32:0] io_cur;
  logic [32:0] mem32_cur;
  logic [63:0] mem64_cur;
  logic [63:0] ptr;
  logic [63:0] low_mask;
  logic [63:0] start;
  logic [63:0] fin;
  logic        over;
  logic        go;

  always_comb begin
    io_cur    = restart ? {1'b0, io_base} : io_free;
    mem32_cur = restart ? {1'b0, mem32_base} : mem32_free;
    mem64_cur = restart ? mem64_base : mem64_free;

    case (dec.win)
      WIN_IO:    ptr = {31'd0, io_cur};
      WIN_MEM32: ptr = {31'd0, mem32_cur};
      default:   ptr = mem64_cur;
    endcase

    // start = align_up(ptr), end = align_up(ptr + size): two parallel adds
    low_mask = {1'b0, dec.span[63:1]};
    start    = (ptr + low_mask) & ~low_mask;
    fin      = (ptr + dec.span) & ~low_mask;
    over     = (dec.win != WIN_MEM64) && (fin > LIMIT32);
    go       = dec.implemented && (dec.status == ST_OK);

    res.implemented   = dec.implemented;
    res.is_io         = dec.is_io;
    res.is_wide       = dec.is_wide;
    res.prefetchable  = dec.prefetchable;
    res.bar_size      = dec.bar_size;
    res.status        = dec.status;
    res.assigned_addr = (go && !over) ? start : 64'd0;
    if (go && over) begin
      res.status = (dec.win == WIN_IO) ? ST_IO_FULL : ST_MEM32_FULL;
    end

    io_free_next    = io_cur;
    mem32_free_next = mem32_cur;
    mem64_free_next = mem64_cur;
    if (go && !over) begin
      case (dec.win)
        WIN_IO:    io_free_next    = fin[32:0];
        WIN_MEM32: mem32_free_next = fin[32:0];
        default:   mem64_free_next = fin;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      io_base    <= '0;
      mem32_base <= '0;
      mem64_base <= '0;
      io_free    <= '0;
      mem32_free <= '0;
      mem64_free <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IO_BASE:    io_base    <= cfg_data[31:0];
          REG_MEM32_BASE: mem32_base <= cfg_data[31:0];
          REG_MEM64_BASE: mem64_base <= cfg_data;
          default: ;
        endcase
      end
      if (step) begin
        io_free    <= io_free_next;
        mem32_free <= mem32_free_next;
        mem64_free <= mem64_free_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/pci_bar_size_and_assign.sv
// A transferred BAR is held, decoded, in the input register, then its result in the result
// register. One BAR per cycle unless the result side stalls; decode sits before the input
// register, and the align-up adds and window compare sit between the input and result registers.
// Reset (rst, synchronous): empties both stages, clears window bases and pointers to zero.
// Top level of the PCI BAR sizing and address assignment block.
// Uses pcibar_pkg, pcibar_decode and pcibar_alloc.
`default_nettype none

module pci_bar_size_and_assign
  import pcibar_pkg::*;
#(
  parameter int NUM_BARS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,

  // Configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,

  // BAR probe channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        restart,
  input  wire logic [2:0]  bar_index,
  input  wire logic [31:0] probe_low,
  input  wire logic [31:0] probe_high,

  // Result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             implemented,
  output logic             is_io,
  output logic             is_wide,
  output logic             prefetchable,
  output logic [63:0]      bar_size,
  output logic [63:0]      assigned_addr,
  output logic [2:0]       status
);

  decoded_t dec_in;
  decoded_t dec;        // input register payload
  logic     dec_valid;
  logic     dec_restart;
  logic     advance;
  result_t  res_calc;
  result_t  res;        // result register payload

  // Decode the probe as it arrives; the input register holds only decoded fields
  pcibar_decode #(
    .NUM_BARS(NUM_BARS)
  ) u_decode (
    .bar_index (bar_index),
    .probe_low (probe_low),
    .probe_high(probe_high),
    .dec       (dec_in)
  );

  // Advance the held BAR when the result register is free or being drained.
  // The pointers update on this same edge, so the next BAR sees them at once.
  assign advance   = dec_valid && (!out_valid || out_ready);
  assign in_ready  = !dec_valid || advance;
  assign cfg_ready = 1'b1;

  pcibar_alloc u_alloc (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .step     (advance),
    .restart  (dec_restart),
    .dec      (dec),
    .res      (res_calc)
  );

  // Input register: hold the decoded BAR until its result is registered
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (in_ready) begin
      dec_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dec         <= dec_in;
      dec_restart <= restart;
    end
  end

  // Result register: hold until the downstream transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_calc;
    end
  end

  assign implemented   = res.implemented;
  assign is_io         = res.is_io;
  assign is_wide       = res.is_wide;
  assign prefetchable  = res.prefetchable;
  assign bar_size      = res.bar_size;
  assign assigned_addr = res.assigned_addr;
  assign status        = res.status;

  // Any error status drops the address
  a_err_no_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (assigned_addr == 64'd0))
    else $error("error result carries an address");

  // An absent BAR reports nothing
  a_absent_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !implemented |-> (bar_size == 64'd0) && (status == ST_OK) && !is_io)
    else $error("absent BAR reports fields");

  // A granted BAR has a power-of-two size and an address aligned to it
  a_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid && implemented && (status == ST_OK) |->
      $onehot(bar_size) && ((assigned_addr & (bar_size - 64'd1)) == 64'd0))
    else $error("granted BAR misaligned or bad size");

  // A stalled output keeps the held BAR in the input register
  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    dec_valid && out_valid && !out_ready |=> dec_valid && $stable(dec))
    else $error("held BAR lost under stall");

endmodule

`default_nettype wire

>>> tb/pcibar_checker.sv
// Checker for the PCI BAR sizing and address assignment block: watches the
// configuration, probe and result channels, predicts each result and compares.
// Depends on pcibar_pkg for the status and register codes and result_t.
module pcibar_checker
  import pcibar_pkg::*;
#(
  parameter int NUM_BARS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        restart,
  input  logic [2:0]  bar_index,
  input  logic [31:0] probe_low,
  input  logic [31:0] probe_high,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        implemented,
  input  logic        is_io,
  input  logic        is_wide,
  input  logic        prefetchable,
  input  logic [63:0] bar_size,
  input  logic [63:0] assigned_addr,
  input  logic [2:0]  status,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PEND_DEPTH = 16;

  logic [31:0] io_base, mem32_base;
  logic [63:0] mem64_base;
  logic [32:0] io_ptr, mem32_ptr;
  logic [63:0] mem64_ptr;

  // Predicted results in transfer order
  result_t pend_q [PEND_DEPTH];
  int      pend_head  = 0;
  int      pend_tail  = 0;
  int      pend_count = 0;
  int      errors = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic logic [63:0] align_up(input logic [63:0] v, input logic [63:0] sz);
    return (v + sz - 64'd1) & ~(sz - 64'd1);
  endfunction

  // Decode one probed BAR, place it in its window and advance that window's pointer.
  function automatic result_t place_bar(input logic rs, input logic [2:0] idx,
                                        input logic [31:0] lo, input logic [31:0] hi);
    result_t     r;
    logic [63:0] mask, sz, start, fin, ptr;
    r     = '0;
    sz    = '0;
    r.status = ST_OK;
    if (rs) begin
      io_ptr    = {1'b0, io_base};
      mem32_ptr = {1'b0, mem32_base};
      mem64_ptr = mem64_base;
    end
    if (lo != 32'd0) begin
      r.implemented = 1'b1;
      if (lo[0]) begin
        r.is_io = 1'b1;
        mask    = {32'd0, lo[31:2], 2'b00};
      end else begin
        r.is_wide      = (lo[2:1] == 2'b10);
        r.prefetchable = lo[3];
        mask = r.is_wide ? {hi, lo[31:4], 4'b0000} : {32'd0, lo[31:4], 4'b0000};
      end
      sz = mask & (~mask + 64'd1);
      if (r.is_wide && int'(idx) + 1 >= NUM_BARS) begin
        r.status = ST_LAST_SLOT;
      end else if (sz == 64'd0) begin
        r.status = ST_ZERO;
      end else if (r.is_wide) begin
        // 64-bit window wraps and never runs out
        start           = align_up(mem64_ptr, sz);
        mem64_ptr       = start + sz;
        r.assigned_addr = start;
      end else begin
        ptr   = r.is_io ? {31'd0, io_ptr} : {31'd0, mem32_ptr};
        start = align_up(ptr, sz);
        fin   = start + sz;
        if (fin > LIMIT32) begin
          r.status = r.is_io ? ST_IO_FULL : ST_MEM32_FULL;
        end else begin
          r.assigned_addr = start;
          if (r.is_io) io_ptr = fin[32:0];
          else mem32_ptr = fin[32:0];
        end
      end
      r.bar_size = (r.status == ST_ZERO || r.status == ST_LAST_SLOT) ? 64'd0 : sz;
      if (r.status != ST_OK) r.assigned_addr = 64'd0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      io_base    = '0;
      mem32_base = '0;
      mem64_base = '0;
      io_ptr     = '0;
      mem32_ptr  = '0;
      mem64_ptr  = '0;
      pend_head  = 0;
      pend_tail  = 0;
      pend_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IO_BASE:    io_base    = cfg_data[31:0];
          REG_MEM32_BASE: mem32_base = cfg_data[31:0];
          REG_MEM64_BASE: mem64_base = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (pend_count == PEND_DEPTH) begin
          errors++;
          if (errors <= 10)
            $display("%0t: more than %0d transfers in flight", $time, PEND_DEPTH);
        end else begin
          pend_q[pend_tail] = place_bar(restart, bar_index, probe_low, probe_high);
          pend_tail = (pend_tail + 1) % PEND_DEPTH;
          pend_count++;
        end
      end
      if (out_valid && out_ready) begin
        got = {implemented, is_io, is_wide, prefetchable, bar_size, assigned_addr, status};
        if (pend_count == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with nothing pending: size=%h addr=%h st=%0d",
                     $time, got.bar_size, got.assigned_addr, got.status);
        end else begin
          want = pend_q[pend_head];
          pend_head = (pend_head + 1) % PEND_DEPTH;
          pend_count--;
          if (want.implemented   !== got.implemented   || want.is_io    !== got.is_io    ||
              want.is_wide       !== got.is_wide       ||
              want.prefetchable  !== got.prefetchable  ||
              want.bar_size      !== got.bar_size      ||
              want.assigned_addr !== got.assigned_addr || want.status   !== got.status) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: mismatch exp impl=%b io=%b wide=%b pf=%b size=%h addr=%h st=%0d",
                        " got impl=%b io=%b wide=%b pf=%b size=%h addr=%h st=%0d"}, $time,
                       want.implemented, want.is_io, want.is_wide, want.prefetchable,
                       want.bar_size, want.assigned_addr, want.status,
                       got.implemented, got.is_io, got.is_wide, got.prefetchable,
                       got.bar_size, got.assigned_addr, got.status);
          end
        end
      end
    end
    fail_count  <= errors;
    outstanding <= pend_count;
  end

endmodule

>>> tb/pci_bar_size_and_assign_tb.sv
// Testbench top for pci_bar_size_and_assign: clock, reset, window setup,
// directed and random BAR probes, result back-pressure and the verdict.
// Depends on pcibar_pkg, the block and pcibar_checker.
module pci_bar_size_and_assign_tb
  import pcibar_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BARS     = 6;
  localparam int RANDOM_BARS  = 145;     // per window setting
  localparam int HOLD_CYCLES  = 80;      // long result stall, fills the pipeline
  localparam int LIMIT_CYCLES = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        restart = 1'b0;
  logic [2:0]  bar_index = '0;
  logic [31:0] probe_low = '0;
  logic [31:0] probe_high = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        implemented, is_io, is_wide, prefetchable;
  logic [63:0] bar_size, assigned_addr;
  logic [2:0]  status;
  int          fail_count;
  int          outstanding;
  int          cycle_count = 0;

  // Sender pacing: alternate between gappy stretches and back-to-back bursts
  int          send_run_left = 0;
  bit          send_gappy = 1'b0;

  pci_bar_size_and_assign #(.NUM_BARS(NUM_BARS)) u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .restart(restart), .bar_index(bar_index),
    .probe_low(probe_low), .probe_high(probe_high),
    .out_valid(out_valid), .out_ready(out_ready), .implemented(implemented), .is_io(is_io),
    .is_wide(is_wide), .prefetchable(prefetchable), .bar_size(bar_size),
    .assigned_addr(assigned_addr), .status(status)
  );

  pcibar_checker #(.NUM_BARS(NUM_BARS)) u_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .restart(restart), .bar_index(bar_index),
    .probe_low(probe_low), .probe_high(probe_high),
    .out_valid(out_valid), .out_ready(out_ready), .implemented(implemented), .is_io(is_io),
    .is_wide(is_wide), .prefetchable(prefetchable), .bar_size(bar_size),
    .assigned_addr(assigned_addr), .status(status),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Write all three window bases back to back; lower valid only after the last transfer.
  task automatic load_windows(input logic [63:0] io_b, input logic [63:0] m32_b,
                              input logic [63:0] m64_b);
    logic [63:0] vals [3];
    logic [1:0]  regs [3];
    vals = '{io_b, m32_b, m64_b};
    regs = '{REG_IO_BASE, REG_MEM32_BASE, REG_MEM64_BASE};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Offer one BAR probe after a random gap and hold it until the transfer.
  task automatic send_bar(input logic rs, input logic [2:0] idx,
                          input logic [31:0] lo, input logic [31:0] hi);
    int gap;
    if (send_run_left == 0) begin
      send_gappy    = $urandom_range(0, 1);
      send_run_left = $urandom_range(10, 60);
    end
    send_run_left--;
    gap = send_gappy ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    restart    <= rs;
    bar_index  <= idx;
    probe_low  <= lo;
    probe_high <= hi;
    do @(posedge clk); while (!in_ready);
  endtask

  // Build a mostly well-formed probe: a size mask with the type bits of a real BAR,
  // with some holes, absent slots, bad indexes and pure noise mixed in.
  task automatic send_random_bar(input logic force_restart);
    int          kind, sh, sh32;
    logic [63:0] m;
    logic        rs, pf;
    logic [1:0]  ty;
    logic [2:0]  idx;
    logic [31:0] lo, hi;
    kind = $urandom_range(0, 99);
    rs   = force_restart || ($urandom_range(0, 15) == 0);
    idx  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    sh   = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 63) : $urandom_range(2, 14);
    sh32 = 2 + (sh % 30);
    pf   = $urandom_range(0, 1);
    ty   = 2'($urandom_range(0, 3));
    hi   = $urandom;
    m    = ~((64'd1 << (kind < 60 ? sh32 : sh)) - 64'd1);
    if ($urandom_range(0, 3) == 0)
      m = (m & {$urandom, $urandom}) | (64'd1 << (kind < 60 ? sh32 : sh));
    if (kind < 6) begin
      lo = 32'd0;
    end else if (kind < 30) begin
      lo = {m[31:2], ty[0], 1'b1};
      // small IO decoders leave the upper half unimplemented
      if ($urandom_range(0, 3) == 0) lo[31:16] = 16'd0;
    end else if (kind < 60) begin
      if ($urandom_range(0, 4) == 0) ty = ty[0] ? 2'b11 : 2'b01;
      else ty = 2'b00;
      lo = {m[31:4], pf, ty, 1'b0};
    end else if (kind < 88) begin
      lo = {m[31:4], pf, 2'b10, 1'b0};
      hi = m[63:32];
    end else begin
      lo = $urandom;
    end
    send_bar(rs, idx, lo, hi);
  endtask

  // Drop valid and let every pending result come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stalls per result, stall-free stretches, and a long hold
  // every few hundred results while the sender keeps offering.
  initial begin
    int  stall;
    int  taken;
    int  run_left;
    bit  gappy;
    taken    = 0;
    run_left = 0;
    gappy    = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (run_left == 0) begin
        gappy    = $urandom_range(0, 1);
        run_left = $urandom_range(10, 60);
      end
      run_left--;
      stall = gappy ? $urandom_range(0, 8) : 0;
      if (taken % 300 == 150) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    logic [63:0] io_b, m32_b, m64_b;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed set on the reset windows (all bases zero)
    send_bar(1'b1, 3'd0, 32'h0000_0000, 32'h0000_0000);  // absent slot
    send_bar(1'b0, 3'd0, 32'hFFFF_FFFD, 32'h0000_0000);  // smallest IO BAR
    send_bar(1'b0, 3'd1, 32'h0000_0001, 32'hFFFF_FFFF);  // IO with empty mask
    send_bar(1'b0, 3'd2, 32'h0000_0003, 32'h0000_0000);
    send_bar(1'b0, 3'd3, 32'h8000_0001, 32'h0000_0000);  // 2 GiB IO, second and third overflow
    send_bar(1'b0, 3'd3, 32'h8000_0001, 32'h0000_0000);
    send_bar(1'b0, 3'd3, 32'h8000_0001, 32'h0000_0000);
    send_bar(1'b0, 3'd0, 32'hFFFF_FFF0, 32'h0000_0000);  // 16-byte memory
    send_bar(1'b0, 3'd1, 32'hFFFF_FFF8, 32'h0000_0000);  // prefetchable
    send_bar(1'b0, 3'd2, 32'hFFFF_FFF2, 32'h0000_0000);  // legacy below-1M type
    send_bar(1'b0, 3'd3, 32'hFFFF_FFF6, 32'h0000_0000);  // reserved type
    send_bar(1'b0, 3'd4, 32'h8000_0000, 32'h0000_0000);  // fill the mem32 window
    send_bar(1'b0, 3'd4, 32'h8000_0000, 32'h0000_0000);
    send_bar(1'b0, 3'd4, 32'h8000_0000, 32'h0000_0000);
    send_bar(1'b0, 3'd5, 32'h0000_0008, 32'h0000_0000);  // memory with empty mask
    send_bar(1'b0, 3'd0, 32'hFFFF_FFF4, 32'hFFFF_FFFF);  // 64-bit, 16 bytes
    send_bar(1'b0, 3'd2, 32'h0000_000C, 32'h8000_0000);  // 64-bit, 2^63, then wrap
    send_bar(1'b0, 3'd3, 32'h0000_0004, 32'h8000_0000);
    send_bar(1'b0, 3'd1, 32'h0000_0004, 32'h0000_0000);  // 64-bit with empty mask
    send_bar(1'b0, 3'd5, 32'hFFFF_FFF4, 32'hFFFF_FFFF);  // 64-bit in the last slot
    send_bar(1'b0, 3'd7, 32'h0000_0004, 32'h0000_0000);  // bad slot beats empty mask
    send_bar(1'b0, 3'd6, 32'hF0F0_F001, 32'h0000_0000);  // IO mask with holes
    send_bar(1'b1, 3'd4, 32'hFFFF_FFFC, 32'hFFFF_0000);  // restart, 64-bit prefetchable
    send_bar(1'b0, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_bar(1'b0, 3'd0, 32'hFFFF_FFFE, 32'h0000_0000);
    drain();

    // Random probes under a range of window settings, extremes included
    for (int phase = 1; phase <= 7; phase++) begin
      case (phase)
        1: begin io_b = '0; m32_b = '0; m64_b = '0; end
        2: begin io_b = '1; m32_b = '1; m64_b = '1; end
        3: begin
          io_b  = 64'h0000_0000_0000_1000;
          m32_b = 64'h0000_0000_8000_0000;
          m64_b = 64'h0000_0040_0000_0000;
        end
        5: begin
          io_b  = 64'h0000_0000_FFFF_F000;
          m32_b = 64'h0000_0000_F000_0000;
          m64_b = 64'hFFFF_FFFF_0000_0000;
        end
        7: begin io_b = '0; m32_b = 64'h0000_0000_C000_0000; m64_b = '0; end
        default: begin
          io_b  = {$urandom, $urandom};
          m32_b = {$urandom, $urandom};
          m64_b = {$urandom, $urandom};
        end
      endcase
      load_windows(io_b, m32_b, m64_b);
      for (int i = 0; i < RANDOM_BARS; i++)
        send_random_bar(i == 0);
      drain();
    end
    repeat (8) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
